@@ hw/rtl/gbci_pkg.sv @@
`default_nettype none

package gbci_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned TICKS_W    = 32;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned ANGLE_W    = 64;
  localparam int unsigned FRAC_SHIFT = 12;
  localparam int unsigned CENTER_FRAC = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN = 2'd1;

  localparam logic [TICKS_W-1:0] CAL_TICKS_RESET = 32'd1000000;
  localparam logic [GAIN_W-1:0]  RATE_GAIN_RESET = 24'd568893;

  localparam logic [ANGLE_W-1:0] ANGLE_SIGN = {1'b1, {(ANGLE_W-1){1'b0}}};

endpackage

`default_nettype wire

@@ hw/rtl/gbci_if.sv @@
`default_nettype none

interface gbci_in_if #(
  parameter int unsigned TIME_BITS   = 32,
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [TIME_BITS-1:0]   timestamp;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output timestamp, output sample, input ready);
  modport sink   (input valid, input timestamp, input sample, output ready);
endinterface

interface gbci_out_if
  import gbci_pkg::*;
#(
  parameter int unsigned CENTER_W = 20
);
  logic                valid;
  logic                ready;
  logic [ANGLE_W-1:0]  angle;
  logic                calibrated;
  logic [CENTER_W-1:0] center_q8;

  modport source (output valid, output angle, output calibrated, output center_q8,
                  input ready);
  modport sink   (input valid, input angle, input calibrated, input center_q8,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gbci_serdiv.sv @@
`default_nettype none

module gbci_serdiv #(
  parameter int unsigned N_W = 36,
  parameter int unsigned D_W = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [N_W-1:0] num_i,
  input  wire logic [D_W-1:0] den_i,
  output logic                done_o,
  output logic [N_W-1:0]      quo_o
);

  localparam int unsigned CNT_W = $clog2(N_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [N_W-1:0]   quo_q, quo_d;
  logic [D_W-1:0]   rem_q, rem_d, den_q;
  logic [D_W:0]     trial, diff;
  logic             ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[N_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? diff[D_W-1:0] : trial[D_W-1:0];
    quo_d = {quo_q[N_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(N_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/gbci_sermul.sv @@
`default_nettype none

module gbci_sermul #(
  parameter int unsigned A_W = 20,
  parameter int unsigned B_W = 24
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [A_W-1:0] a_i,
  input  wire logic [B_W-1:0] b_i,
  output logic                done_o,
  output logic [A_W+B_W-1:0]  prod_o
);

  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic               busy_q, done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [A_W-1:0]     a_q;
  logic [A_W+B_W-1:0] acc_q, acc_d;
  logic [A_W:0]       part;

  // shift-add, one multiplier bit retired per cycle
  always_comb begin
    part  = {1'b0, acc_q[A_W+B_W-1:B_W]} + {1'b0, (acc_q[0] ? a_q : {A_W{1'b0}})};
    acc_d = {part, acc_q[B_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(B_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      acc_q <= {{A_W{1'b0}}, b_i};
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

@@ hw/rtl/gyro_bias_calibrate_integrate.sv @@
// Gyro bias calibration and rate integration.
// Input channel in_i carries timestamp and sample; a transfer takes place when
// valid and ready are both high. Output channel out_o carries one result per
// input: angle, calibrated and center_q8.
// The first sample opens the calibration window. Samples inside the window
// update the running mean through a bit-serial restoring divider, one quotient
// bit per cycle. After the window, each sample goes through two bit-serial
// shift-add multipliers in series (offset times gain, then times elapsed
// ticks), one multiplier bit per cycle, then a round/saturate step and a
// saturating add. The first sample after calibration only records its time.
// in_i.ready is high while no item is in work; one finished result may wait in
// the output register while the next item is taken. If the receiver stalls,
// the finished item holds until the output register frees.
// Reset clears all calibration and integration state and loads the default
// window length and gain. cfg_we_i writes register cfg_idx_i (0 window length,
// 1 gain); the user must use it only while the block is idle (not enforced).
`default_nettype none

module gyro_bias_calibrate_integrate
  import gbci_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned COUNT_BITS  = 16,
  parameter int unsigned TIME_BITS   = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  gbci_in_if.sink                    in_i,
  gbci_out_if.source                 out_o
);

  localparam int unsigned CW    = SAMPLE_BITS + CENTER_FRAC;
  localparam int unsigned SUM_W = SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned NUM_W = SUM_W + CENTER_FRAC;
  localparam int unsigned P1_W  = CW + GAIN_W;
  localparam int unsigned P2_W  = P1_W + TIME_BITS;
  localparam int unsigned TOP_W = ANGLE_W + FRAC_SHIFT;
  localparam int unsigned EXT_W = (P2_W + 1 > TOP_W + 1) ? P2_W + 1 : TOP_W + 1;
  localparam int unsigned CMP_W = (TIME_BITS > TICKS_W) ? TIME_BITS : TICKS_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]             state_q;
  logic [TICKS_W-1:0]     cal_ticks_q;
  logic [GAIN_W-1:0]      rate_gain_q;
  logic                   cal_started_q, int_started_q;
  logic [TIME_BITS-1:0]   cal_start_q, last_time_q, elapsed_q;
  logic [SUM_W-1:0]       cal_sum_q;
  logic [COUNT_BITS-1:0]  cal_count_q;
  logic [CW-1:0]          center_q, diff_q;
  logic                   neg_q, calib_q;
  logic [ANGLE_W-1:0]     angle_q, mag_q;
  logic                   div_start_q, mul_start_q;
  logic                   out_valid_q, out_cal_q;
  logic [ANGLE_W-1:0]     out_angle_q;
  logic [CW-1:0]          out_center_q;

  logic                   in_xfer, out_free, done_c;
  logic [TIME_BITS-1:0]   win_diff;
  logic [CW-1:0]          scaled, diff_c;
  logic                   neg_c;
  logic                   div_done, mul1_done, mul2_done;
  logic [NUM_W-1:0]       quo;
  logic [P1_W-1:0]        prod1;
  logic [P2_W-1:0]        prod2;
  logic [EXT_W-1:0]       rounded;
  logic [ANGLE_W-1:0]     mag_c, bias_off, angle_c;
  logic [ANGLE_W:0]       sum_pos, sum_neg;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    win_diff = in_i.timestamp - cal_start_q;
    done_c   = cal_started_q && (CMP_W'(win_diff) > CMP_W'(cal_ticks_q));
    scaled   = {in_i.sample, {CENTER_FRAC{1'b0}}};
    neg_c    = scaled < center_q;
    diff_c   = neg_c ? (center_q - scaled) : (scaled - center_q);
  end

  gbci_serdiv #(.N_W(NUM_W), .D_W(COUNT_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   ({cal_sum_q, {CENTER_FRAC{1'b0}}}),
    .den_i   (cal_count_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  gbci_sermul #(.A_W(CW), .B_W(GAIN_W)) u_mul_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (diff_q),
    .b_i     (rate_gain_q),
    .done_o  (mul1_done),
    .prod_o  (prod1)
  );

  gbci_sermul #(.A_W(P1_W), .B_W(TIME_BITS)) u_mul_time (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul1_done),
    .a_i     (prod1),
    .b_i     (elapsed_q),
    .done_o  (mul2_done),
    .prod_o  (prod2)
  );

  // round toward minus infinity for negative offsets, shift, saturate
  always_comb begin
    rounded = EXT_W'(prod2) + (neg_q ? EXT_W'({FRAC_SHIFT{1'b1}}) : EXT_W'(0));
    mag_c   = (|rounded[EXT_W-1:TOP_W]) ? {ANGLE_W{1'b1}} : rounded[TOP_W-1:FRAC_SHIFT];
  end

  // saturating add in offset binary
  always_comb begin
    bias_off = angle_q ^ ANGLE_SIGN;
    sum_pos  = {1'b0, bias_off} + {1'b0, mag_q};
    sum_neg  = {1'b0, bias_off} - {1'b0, mag_q};
    if (neg_q) begin
      angle_c = (sum_neg[ANGLE_W] ? {ANGLE_W{1'b0}} : sum_neg[ANGLE_W-1:0]) ^ ANGLE_SIGN;
    end else begin
      angle_c = (sum_pos[ANGLE_W] ? {ANGLE_W{1'b1}} : sum_pos[ANGLE_W-1:0]) ^ ANGLE_SIGN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_ticks_q <= CAL_TICKS_RESET;
      rate_gain_q <= RATE_GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CAL_TICKS: cal_ticks_q <= cfg_data_i[TICKS_W-1:0];
        REG_RATE_GAIN: rate_gain_q <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cal_started_q <= 1'b0;
      cal_start_q   <= '0;
      cal_sum_q     <= '0;
      cal_count_q   <= '0;
      center_q      <= '0;
      int_started_q <= 1'b0;
      last_time_q   <= '0;
      angle_q       <= '0;
      div_start_q   <= 1'b0;
      mul_start_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      div_start_q <= (state_q == ST_IDLE) && in_xfer && !done_c;
      mul_start_q <= (state_q == ST_IDLE) && in_xfer && done_c && int_started_q;
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (done_c) begin
              int_started_q <= 1'b1;
              last_time_q   <= in_i.timestamp;
              if (int_started_q) begin
                state_q <= ST_MUL;
              end else begin
                state_q <= ST_FIN;
              end
            end else begin
              if (!cal_started_q) begin
                cal_started_q <= 1'b1;
                cal_start_q   <= in_i.timestamp;
              end
              if (cal_count_q != {COUNT_BITS{1'b1}}) begin
                cal_sum_q   <= cal_sum_q + SUM_W'(in_i.sample);
                cal_count_q <= cal_count_q + COUNT_BITS'(1);
              end
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            center_q <= quo[CW-1:0];
            state_q  <= ST_FIN;
          end
        end
        ST_MUL: begin
          if (mul2_done) begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          angle_q <= angle_c;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_xfer) begin
      calib_q   <= done_c;
      elapsed_q <= in_i.timestamp - last_time_q;
      diff_q    <= diff_c;
      neg_q     <= neg_c;
    end
    if (state_q == ST_MUL && mul2_done) begin
      mag_q <= mag_c;
    end
    if (state_q == ST_FIN && out_free) begin
      out_angle_q  <= angle_q;
      out_cal_q    <= calib_q;
      out_center_q <= center_q;
    end
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.angle      = out_angle_q;
  assign out_o.calibrated = out_cal_q;
  assign out_o.center_q8  = out_center_q;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import gbci_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 1000000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 200;
  localparam logic [31:0] T0            = 32'hFFFF_FF00;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX  = ~ANGLE_SIGN;
  localparam logic [127:0]       ROUND_DOWN = (128'd1 << FRAC_SHIFT) - 128'd1;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               calibrated;
    logic [19:0]        center_q8;
  } reading_t;

  typedef struct packed {
    logic     pinned;
    reading_t want;
  } typed_reading_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [31:0] a;
    logic [31:0] b;
    logic        pinned;
    reading_t    want;
  } script_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  gbci_in_if #(.TIME_BITS(32), .SAMPLE_BITS(12)) in_if ();
  gbci_out_if #(.CENTER_W(20)) out_if ();

  gyro_bias_calibrate_integrate dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // predictor state and register copies
  logic [TICKS_W-1:0] window_ticks  = CAL_TICKS_RESET;
  logic [GAIN_W-1:0]  gain_q12      = RATE_GAIN_RESET;
  logic               window_open   = 1'b0;
  logic [31:0]        window_origin = '0;
  logic [27:0]        code_sum      = '0;
  logic [15:0]        code_count    = '0;
  logic [19:0]        bias_q8       = '0;
  logic               rate_armed    = 1'b0;
  logic [31:0]        prev_ts       = '0;
  logic [ANGLE_W-1:0] heading       = '0;

  reading_t       pending_readings[$];
  typed_reading_t typed_readings[$];
  script_row_t    script[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  logic        hold_req       = 1'b0;
  logic        idle_on        = 1'b1;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic reading_t integrate_sample(input logic [31:0] ts, input logic [11:0] smp);
    logic [31:0]        since_start;
    logic [31:0]        elapsed;
    logic [19:0]        scaled;
    logic [19:0]        offset;
    logic               below;
    logic               done;
    logic [127:0]       product;
    logic [63:0]        incr;
    logic [ANGLE_W-1:0] biased;
    reading_t           res;
    since_start = ts - window_origin;
    done = window_open && (since_start > window_ticks);
    if (done) begin
      if (rate_armed) begin
        elapsed = ts - prev_ts;
        scaled  = {smp, 8'd0};
        below   = scaled < bias_q8;
        offset  = below ? bias_q8 - scaled : scaled - bias_q8;
        product = 128'(offset) * 128'(gain_q12) * 128'(elapsed) + (below ? ROUND_DOWN : '0);
        product = product >> FRAC_SHIFT;
        incr    = (product[127:64] != '0) ? '1 : product[63:0];
        // offset binary makes the clamp an unsigned compare
        biased = heading ^ ANGLE_SIGN;
        if (below) begin
          biased = (incr > biased) ? '0 : biased - incr;
        end else begin
          biased = (incr > ~biased) ? '1 : biased + incr;
        end
        heading = biased ^ ANGLE_SIGN;
      end
      rate_armed = 1'b1;
      prev_ts    = ts;
    end else begin
      if (!window_open) begin
        window_open   = 1'b1;
        window_origin = ts;
      end
      if (code_count != '1) begin
        code_sum   = code_sum + 28'(smp);
        code_count = code_count + 16'd1;
      end
      bias_q8 = 20'({code_sum, 8'd0} / 36'(code_count));
    end
    res.angle      = heading;
    res.calibrated = done;
    res.center_q8  = bias_q8;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : scoreboard
    reading_t       predicted;
    reading_t       want;
    typed_reading_t tag;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_readings.size() == 0) begin
          report_mismatch("unexpected result angle", out_if.angle, '0);
        end else begin
          want = pending_readings.pop_front();
          if (out_if.angle !== want.angle)
            report_mismatch("angle", out_if.angle, want.angle);
          if (out_if.calibrated !== want.calibrated)
            report_mismatch("calibrated", 64'(out_if.calibrated), 64'(want.calibrated));
          if (out_if.center_q8 !== want.center_q8)
            report_mismatch("center_q8", 64'(out_if.center_q8), 64'(want.center_q8));
        end
      end
      if (in_if.valid && in_if.ready) begin
        predicted = integrate_sample(in_if.timestamp, in_if.sample);
        tag = typed_readings.pop_front();
        pending_readings.push_back(tag.pinned ? tag.want : predicted);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned held;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req     <= 1'b0;
        out_if.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic script_row_t sample_row(input logic [31:0] ts, input logic [11:0] smp);
    script_row_t row;
    row.kind   = ROW_SAMPLE;
    row.a      = ts;
    row.b      = 32'(smp);
    row.pinned = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  function automatic script_row_t pinned_row(input logic [31:0] ts, input logic [11:0] smp,
                                             input logic [63:0] angle, input logic cal,
                                             input logic [19:0] center);
    script_row_t row;
    row = sample_row(ts, smp);
    row.pinned          = 1'b1;
    row.want.angle      = angle;
    row.want.calibrated = cal;
    row.want.center_q8  = center;
    return row;
  endfunction

  function automatic script_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
    script_row_t row;
    row.kind   = ROW_WRITE;
    row.a      = 32'(idx);
    row.b      = data;
    row.pinned = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  task automatic send_sample(input logic [31:0] ts, input logic [11:0] smp,
                             input logic pin, input reading_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.timestamp <= ts;
    in_if.sample    <= smp;
    typed_readings.push_back({pin, want});
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic settle_block();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_CAL_TICKS: window_ticks = data[TICKS_W-1:0];
      REG_RATE_GAIN: gain_q12 = data[GAIN_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned kind_roll;
    int unsigned smp_roll;
    int          near;
    logic [31:0] ts;
    logic [31:0] since;
    logic [31:0] t_walk;
    logic [11:0] smp;
    logic [31:0] new_window;
    logic [31:0] new_gain;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_CAL_TICKS;
    cfg_data_i      <= '0;
    in_if.valid     <= 1'b0;
    in_if.timestamp <= '0;
    in_if.sample    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // window opens just below the time wrap
    script.push_back(pinned_row(T0, 12'd4095, '0, 1'b0, 20'd1048320));
    script.push_back(pinned_row(T0 + 32'd10, 12'd0, '0, 1'b0, 20'd524160));
    script.push_back(sample_row(T0 + 32'd20, 12'd2048));
    script.push_back(sample_row(T0 + 32'd1000000, 12'd1));
    script.push_back(pinned_row(T0 + 32'd1000001, 12'd7, '0, 1'b1, 20'd393216));
    script.push_back(sample_row(T0 + 32'd1000002, 12'd4095));
    script.push_back(sample_row(T0 + 32'd1000003, 12'd0));
    script.push_back(sample_row(T0 + 32'd1000003, 12'd0));
    // clock steps back into the window
    script.push_back(sample_row(T0 + 32'd5, 12'd3000));
    script.push_back(sample_row(T0 + 32'd1000103, 12'd1536));
    script.push_back(write_row(REG_RATE_GAIN, 32'h00FF_FFFF));
    script.push_back(pinned_row(T0 + 32'd1000102, 12'd4095, ANGLE_MAX, 1'b1, 20'd468172));
    script.push_back(sample_row(T0 + 32'd1000101, 12'd4095));
    script.push_back(sample_row(T0 + 32'd1000100, 12'd0));
    script.push_back(sample_row(T0 + 32'd1000099, 12'd0));
    script.push_back(pinned_row(T0 + 32'd1000098, 12'd0, ANGLE_SIGN, 1'b1, 20'd468172));
    script.push_back(write_row(REG_RATE_GAIN, 32'h0000_0000));
    script.push_back(sample_row(T0 + 32'd1000097, 12'd2222));
    script.push_back(write_row(REG_CAL_TICKS, 32'hFFFF_FFFF));
    script.push_back(sample_row(T0 + 32'd1000096, 12'd4095));
    script.push_back(write_row(REG_CAL_TICKS, 32'd1));
    script.push_back(write_row(REG_SPARE_A, 32'hDEAD_BEEF));
    script.push_back(write_row(REG_SPARE_B, 32'hFFFF_FFFF));
    script.push_back(sample_row(T0 + 32'd1, 12'd7));
    script.push_back(sample_row(T0 + 32'd2, 12'd100));
    script.push_back(write_row(REG_RATE_GAIN, 32'(RATE_GAIN_RESET)));
    script.push_back(sample_row(T0 + 32'd3, 12'd4000));

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        settle_block();
        write_reg(script[i].a[CFG_IDX_W-1:0], script[i].b);
      end else begin
        send_sample(script[i].a, script[i].b[11:0], script[i].pinned, script[i].want);
      end
    end
    t_walk = T0 + 32'd3;

    for (phase = 0; phase < PHASES; phase++) begin
      settle_block();
      if (phase == PHASES - 1) idle_on <= 1'b0;
      case (phase)
        0: begin new_window = 32'd1; new_gain = 32'h00FF_FFFF; end
        1: begin new_window = $urandom_range(1, 50000); new_gain = $urandom_range(0, 4096); end
        2: begin new_window = $urandom_range(100, 2000000); new_gain = $urandom(); end
        3: begin new_window = 32'hFFFF_FFFF; new_gain = 32'(RATE_GAIN_RESET); end
        4: begin
          new_window = 32'(CAL_TICKS_RESET);
          new_gain   = $urandom_range(0, 32'h0010_0000);
        end
        default: begin
          new_window = $urandom_range(1, 32'h0010_0000);
          new_gain   = $urandom_range(0, 32'h00FF_FFFF);
        end
      endcase
      write_reg(REG_CAL_TICKS, new_window);
      write_reg(REG_RATE_GAIN, new_gain);
      if (phase == 2) hold_req <= 1'b1;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == PHASE_ITEMS / 2) settle_block();
        kind_roll = $urandom_range(0, 99);
        if (kind_roll < 65) begin
          ts    = t_walk + $urandom_range(0, 3000);
          since = ts - T0;
          if (since <= window_ticks)
            ts = T0 + window_ticks + 32'd1 + $urandom_range(0, 3000);
        end else if (kind_roll < 80) begin
          ts = T0 + $urandom_range(0, window_ticks);
        end else if (kind_roll < 90) begin
          ts = t_walk + $urandom();
        end else begin
          ts = $urandom();
        end
        smp_roll = $urandom_range(0, 9);
        if (smp_roll < 5) begin
          smp = 12'($urandom_range(0, 4095));
        end else if (smp_roll < 9) begin
          near = int'(bias_q8[19:8]) + int'($urandom_range(0, 80)) - 40;
          smp  = (near < 0) ? 12'd0 : (near > 4095) ? 12'd4095 : 12'(near);
        end else begin
          smp = ($urandom_range(0, 1) == 1) ? 12'hFFF : 12'h000;
        end
        send_sample(ts, smp, 1'b0, '0);
        t_walk = ts;
      end
    end

    settle_block();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/gbci_pkg.sv
hw/rtl/gbci_if.sv
hw/rtl/gbci_serdiv.sv
hw/rtl/gbci_sermul.sv
hw/rtl/gyro_bias_calibrate_integrate.sv
dv/tb_top.sv
